[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/q2e_pkg.sv]
// ----------------------------------------------------------------------------
// q2e_pkg
// Constants, payload types and the arctangent table of the converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

    // Output angle width; 2^(ANGLE_W-1) stands for pi.
    localparam int ANGLE_W  = 16;
    localparam int CORDIC_N = 16;
    // One square-root cell per result bit of a 61-bit radicand.
    localparam int SQRT_N   = 31;
    localparam int FRONT_N  = 3;

    // Stage numbering of the whole pipeline.
    localparam int PRE_IDX     = FRONT_N + SQRT_N;
    localparam int CORDIC_IDX0 = PRE_IDX + 1;
    localparam int OUT_IDX     = CORDIC_IDX0 + CORDIC_N;
    localparam int STAGE_N     = OUT_IDX + 1;

    localparam int LANE_W = 36;
    localparam int ZACC_W = 34;
    localparam logic signed [ZACC_W-1:0] HALF_PI_ACC = ZACC_W'(64'sd1073741824);

    // Quantities that travel beside the square-root chain.
    typedef struct packed {
        logic signed [31:0] sr;
        logic signed [31:0] cr;
        logic signed [31:0] sy;
        logic signed [31:0] cy;
        logic signed [30:0] s;
        logic               clamp;
        logic               s_pos;
    } side_t;

    // One vectoring CORDIC lane.
    typedef struct packed {
        logic signed [LANE_W-1:0] x;
        logic signed [LANE_W-1:0] y;
        logic signed [ZACC_W-1:0] z;
        logic                     zero;
    } lane_t;

    // atan(2^-i), 2^32 is a full turn.
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81,
        32'd41, 32'd20, 32'd10, 32'd5,
        32'd3, 32'd1, 32'd1, 32'd0
    };

endpackage

[sv/q2e_front.sv]
// ----------------------------------------------------------------------------
// q2e_front
// Component products, saturated product sums and the arcsine radicand.
// ----------------------------------------------------------------------------
module q2e_front
(
    input  logic                    clk,
    input  logic [2:0]              en,
    input  logic signed [15:0]      quat_w,
    input  logic signed [15:0]      quat_x,
    input  logic signed [15:0]      quat_y,
    input  logic signed [15:0]      quat_z,
    output q2e_pkg::side_t          side,
    output logic [60:0]             rad
);

    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg;
    logic signed [31:0] xy_reg, zz_reg, wy_reg, zx_reg;
    q2e_pkg::side_t     sum_reg, sum_next;
    q2e_pkg::side_t     side_reg;
    logic [60:0]        rad_reg, rad_next;
    logic signed [33:0] s_full;
    logic signed [61:0] s_sq;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Stage one: the nine component products.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            wx_reg <= quat_w * quat_x;
            yz_reg <= quat_y * quat_z;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            wz_reg <= quat_w * quat_z;
            xy_reg <= quat_x * quat_y;
            zz_reg <= quat_z * quat_z;
            wy_reg <= quat_w * quat_y;
            zx_reg <= quat_z * quat_x;
        end
    end

    // Stage two: doubled sums at scale 2^30, saturated to 32 bits.
    always_comb
    begin
        s_full = 34'(2) * (34'(wy_reg) - 34'(zx_reg));
        sum_next.sr = sat32(34'(2) * (34'(wx_reg) + 34'(yz_reg)));
        sum_next.cr = sat32(34'sd1073741824 - 34'(2) * (34'(xx_reg) + 34'(yy_reg)));
        sum_next.sy = sat32(34'(2) * (34'(wz_reg) + 34'(xy_reg)));
        sum_next.cy = sat32(34'sd1073741824 - 34'(2) * (34'(yy_reg) + 34'(zz_reg)));
        sum_next.s = s_full[30:0];
        sum_next.clamp = (s_full >= 34'sd1073741824) || (s_full <= -34'sd1073741824);
        sum_next.s_pos = (s_full > 34'sd0);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            sum_reg <= sum_next;
    end

    // Stage three: radicand 1 - s^2 at scale 2^60.
    always_comb
    begin
        s_sq = 62'(sum_reg.s) * 62'(sum_reg.s);
        rad_next = 61'(62'sd1152921504606846976 - s_sq);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            side_reg <= sum_reg;
            rad_reg <= rad_next;
        end
    end

    assign side = side_reg;
    assign rad = rad_reg;

endmodule

[sv/q2e_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One result bit of the restoring integer square root.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell
(
    input  logic                clk,
    input  logic                en,
    input  logic [4:0]          bit_idx,
    input  logic [60:0]         rem_in,
    input  logic [61:0]         res_in,
    input  q2e_pkg::side_t      side_in,
    output logic [60:0]         rem_out,
    output logic [61:0]         res_out,
    output q2e_pkg::side_t      side_out
);

    logic [60:0]    rem_reg, rem_next;
    logic [61:0]    res_reg, res_next;
    q2e_pkg::side_t side_reg;
    logic [61:0]    bit_val;
    logic [61:0]    trial;

    // Try to subtract the next candidate; keep the root bit if it fits.
    always_comb
    begin
        bit_val = 62'(1) << {bit_idx, 1'b0};
        trial = res_in + bit_val;
        if ({1'b0, rem_in} >= trial)
        begin
            rem_next = rem_in - trial[60:0];
            res_next = (res_in >> 1) + bit_val;
        end
        else
        begin
            rem_next = rem_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
            side_reg <= side_in;
        end
    end

    assign rem_out = rem_reg;
    assign res_out = res_reg;
    assign side_out = side_reg;

endmodule

[sv/q2e_cordic_cell.sv]
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One micro-rotation of a vectoring CORDIC lane.
// ----------------------------------------------------------------------------
module q2e_cordic_cell
(
    input  logic                clk,
    input  logic                en,
    input  logic [4:0]          shift_idx,
    input  q2e_pkg::lane_t      lane_in,
    output q2e_pkg::lane_t      lane_out
);

    q2e_pkg::lane_t lane_reg, lane_next;
    logic signed [q2e_pkg::LANE_W-1:0] dx;
    logic signed [q2e_pkg::LANE_W-1:0] dy;
    logic signed [q2e_pkg::ZACC_W-1:0] da;

    // Rotate toward the x axis and accumulate the angle.
    always_comb
    begin
        dx = lane_in.y >>> shift_idx;
        dy = lane_in.x >>> shift_idx;
        da = q2e_pkg::ZACC_W'(q2e_pkg::ATAN_TAB[shift_idx]);
        lane_next.zero = lane_in.zero;
        if (lane_in.y > 0)
        begin
            lane_next.x = lane_in.x + dx;
            lane_next.y = lane_in.y - dy;
            lane_next.z = lane_in.z + da;
        end
        else
        begin
            lane_next.x = lane_in.x - dx;
            lane_next.y = lane_in.y + dy;
            lane_next.z = lane_in.z - da;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule

[sv/quaternion_to_euler.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Unit quaternion (Q1.15) to roll, pitch and yaw binary angles, ZYX order.
// ----------------------------------------------------------------------------
// Input channel: quat_valid / quat_stall with quat_w, quat_x, quat_y, quat_z.
// Output channel: euler_valid / euler_stall with roll_angle, pitch_angle,
// yaw_angle and pitch_clamped. An item moves when valid is high and stall low.
// Stages: products, sums, radicand, 31 square-root cells (one per root bit),
// one quadrant stage, 16 CORDIC cells and the output register.
// Throughput is one item per clock unless stalled; every stage has its
// own valid bit, so the pipeline accepts items while it has an empty slot.
// When the receiver stalls, the output item holds and the stages behind it
// fill up one by one; quat_stall rises only when the first stage is full
// and cannot move. Reset clears all valid bits; no item is in flight after.
// Pitch is asin(s) as atan2(s, sqrt(1 - s^2)); when |s| reaches one it is
// forced to plus or minus half pi and pitch_clamped is set.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_to_euler
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                quat_valid,
    output logic                quat_stall,
    input  logic signed [15:0]  quat_w,
    input  logic signed [15:0]  quat_x,
    input  logic signed [15:0]  quat_y,
    input  logic signed [15:0]  quat_z,
    output logic                euler_valid,
    input  logic                euler_stall,
    output logic signed [15:0]  roll_angle,
    output logic signed [15:0]  pitch_angle,
    output logic signed [15:0]  yaw_angle,
    output logic                pitch_clamped
);

    localparam int AW = q2e_pkg::ANGLE_W;
    localparam logic signed [AW-1:0] LIM = AW'(1) <<< (AW - 2);

    logic [q2e_pkg::STAGE_N-1:0] vld_reg;
    logic [q2e_pkg::STAGE_N:0]   en;

    logic [60:0]    rem_s  [q2e_pkg::SQRT_N+1];
    logic [61:0]    res_s  [q2e_pkg::SQRT_N+1];
    q2e_pkg::side_t side_s [q2e_pkg::SQRT_N+1];

    q2e_pkg::lane_t roll_l  [q2e_pkg::CORDIC_N+1];
    q2e_pkg::lane_t yaw_l   [q2e_pkg::CORDIC_N+1];
    q2e_pkg::lane_t pitch_l [q2e_pkg::CORDIC_N+1];
    logic           clamp_s [q2e_pkg::CORDIC_N+1];
    logic           spos_s  [q2e_pkg::CORDIC_N+1];

    q2e_pkg::side_t side_end;
    logic signed [AW-1:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [AW-1:0] pitch_raw, pitch_next;
    logic                 clamp_reg;

    // Quadrant correction and zero detection ahead of the CORDIC.
    function automatic q2e_pkg::lane_t prerot(input logic signed [q2e_pkg::LANE_W-1:0] yv,
                                              input logic signed [q2e_pkg::LANE_W-1:0] xv);
        q2e_pkg::lane_t l;
        l.zero = (xv == '0) && (yv == '0);
        l.x = xv;
        l.y = yv;
        l.z = '0;
        if (xv < 0)
        begin
            if (yv >= 0)
            begin
                l.x = yv;
                l.y = -xv;
                l.z = q2e_pkg::HALF_PI_ACC;
            end
            else
            begin
                l.x = -yv;
                l.y = xv;
                l.z = -q2e_pkg::HALF_PI_ACC;
            end
        end
        return l;
    endfunction

    // Round the 34-bit accumulator angle to the output width.
    function automatic logic signed [AW-1:0] to_angle(input q2e_pkg::lane_t l);
        logic signed [q2e_pkg::ZACC_W-1:0] zr;
        zr = l.zero ? '0 : l.z + (q2e_pkg::ZACC_W'(1) <<< (31 - AW));
        return zr[31 -: AW];
    endfunction

    // Per-stage advance: a stage moves when it is empty or its successor moves.
    always_comb
    begin
        en[q2e_pkg::STAGE_N] = !euler_stall;
        for (int k = q2e_pkg::STAGE_N - 1; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= quat_valid;
            for (int k = 1; k < q2e_pkg::STAGE_N; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign quat_stall = !en[0];
    assign euler_valid = vld_reg[q2e_pkg::OUT_IDX];

    // Products, sums and radicand.
    q2e_front u_front
    (
        .clk    (clk),
        .en     (en[2:0]),
        .quat_w (quat_w),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z),
        .side   (side_s[0]),
        .rad    (rem_s[0])
    );

    assign res_s[0] = '0;

    // Square-root chain, most significant root bit first.
    for (genvar k = 0; k < q2e_pkg::SQRT_N; k++)
    begin : g_sqrt
        q2e_sqrt_cell u_cell
        (
            .clk      (clk),
            .en       (en[q2e_pkg::FRONT_N + k]),
            .bit_idx  (5'(q2e_pkg::SQRT_N - 1 - k)),
            .rem_in   (rem_s[k]),
            .res_in   (res_s[k]),
            .side_in  (side_s[k]),
            .rem_out  (rem_s[k+1]),
            .res_out  (res_s[k+1]),
            .side_out (side_s[k+1])
        );
    end

    assign side_end = side_s[q2e_pkg::SQRT_N];

    // Quadrant stage for the three atan2 lanes.
    always_ff @(posedge clk)
    begin
        if (en[q2e_pkg::PRE_IDX])
        begin
            roll_l[0] <= prerot(q2e_pkg::LANE_W'(side_end.sr), q2e_pkg::LANE_W'(side_end.cr));
            yaw_l[0] <= prerot(q2e_pkg::LANE_W'(side_end.sy), q2e_pkg::LANE_W'(side_end.cy));
            pitch_l[0] <= prerot(q2e_pkg::LANE_W'(side_end.s),
                                 q2e_pkg::LANE_W'(res_s[q2e_pkg::SQRT_N][30:0]));
            clamp_s[0] <= side_end.clamp;
            spos_s[0] <= side_end.s_pos;
        end
    end

    // CORDIC chain, three lanes side by side.
    for (genvar i = 0; i < q2e_pkg::CORDIC_N; i++)
    begin : g_cordic
        q2e_cordic_cell u_roll
        (
            .clk       (clk),
            .en        (en[q2e_pkg::CORDIC_IDX0 + i]),
            .shift_idx (5'(i)),
            .lane_in   (roll_l[i]),
            .lane_out  (roll_l[i+1])
        );
        q2e_cordic_cell u_yaw
        (
            .clk       (clk),
            .en        (en[q2e_pkg::CORDIC_IDX0 + i]),
            .shift_idx (5'(i)),
            .lane_in   (yaw_l[i]),
            .lane_out  (yaw_l[i+1])
        );
        q2e_cordic_cell u_pitch
        (
            .clk       (clk),
            .en        (en[q2e_pkg::CORDIC_IDX0 + i]),
            .shift_idx (5'(i)),
            .lane_in   (pitch_l[i]),
            .lane_out  (pitch_l[i+1])
        );

        always_ff @(posedge clk)
        begin
            if (en[q2e_pkg::CORDIC_IDX0 + i])
            begin
                clamp_s[i+1] <= clamp_s[i];
                spos_s[i+1] <= spos_s[i];
            end
        end
    end

    // Pitch limiting: forced on saturation, clipped otherwise.
    always_comb
    begin
        pitch_raw = to_angle(pitch_l[q2e_pkg::CORDIC_N]);
        if (clamp_s[q2e_pkg::CORDIC_N])
            pitch_next = spos_s[q2e_pkg::CORDIC_N] ? LIM : -LIM;
        else if (pitch_raw > LIM)
            pitch_next = LIM;
        else if (pitch_raw < -LIM)
            pitch_next = -LIM;
        else
            pitch_next = pitch_raw;
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en[q2e_pkg::OUT_IDX])
        begin
            roll_reg <= to_angle(roll_l[q2e_pkg::CORDIC_N]);
            yaw_reg <= to_angle(yaw_l[q2e_pkg::CORDIC_N]);
            pitch_reg <= pitch_next;
            clamp_reg <= clamp_s[q2e_pkg::CORDIC_N];
        end
    end

    assign roll_angle = 16'(roll_reg);
    assign pitch_angle = 16'(pitch_reg);
    assign yaw_angle = 16'(yaw_reg);
    assign pitch_clamped = clamp_reg;

    `ASSERT_IMPLY(a_clamp_value, clk, rst_n, euler_valid && pitch_clamped,
                  (pitch_reg == LIM) || (pitch_reg == -LIM))
    `ASSERT_IMPLY(a_pitch_range, clk, rst_n, euler_valid,
                  (pitch_reg <= LIM) && (pitch_reg >= -LIM))
    `ASSERT_NEXT(a_hold_behind, clk, rst_n,
                 euler_valid && euler_stall && vld_reg[q2e_pkg::OUT_IDX-1],
                 vld_reg[q2e_pkg::OUT_IDX-1])

endmodule
